### rtl/core/stl_pkg.sv
// ----------------------------------------------------------------------------
// stl_pkg: shared types and constants for the script token lexer
// Token codes, lexer modes and the record carried from front to back.
// ----------------------------------------------------------------------------
`default_nettype none
package stl_pkg;

  localparam int LineBits = 16;
  localparam int MantBits = 64;
  localparam int QDepth   = 4;
  localparam int QAw      = 2;

  typedef enum logic [3:0] {
    M_IDLE, M_SLASH, M_COMMENT, M_INT, M_FRAC, M_EXP_START, M_EXP_SIGN,
    M_EXP_DIG, M_STR, M_STR_ESC, M_IDENT, M_OP_PEND
  } mode_e;

  localparam logic [5:0] TkEof     = 6'd0;
  localparam logic [5:0] TkInt     = 6'd1;
  localparam logic [5:0] TkFloat   = 6'd2;
  localparam logic [5:0] TkStr     = 6'd3;
  localparam logic [5:0] TkIdent   = 6'd4;
  localparam logic [5:0] TkKw0     = 6'd5;
  localparam logic [5:0] TkAssign  = 6'd20;
  localparam logic [5:0] TkNot     = 6'd21;
  localparam logic [5:0] TkDiv     = 6'd23;
  localparam logic [5:0] TkEq      = 6'd27;
  localparam logic [5:0] TkNe      = 6'd28;
  localparam logic [5:0] TkOr      = 6'd31;
  localparam logic [5:0] TkAnd     = 6'd32;
  localparam logic [5:0] TkBad     = 6'd33;
  localparam logic [5:0] TkOpenStr = 6'd34;

  typedef struct packed {
    logic                rec;
    logic [5:0]          tok;
    logic [7:0]          byte_v;
    logic [31:0]         ival;
    logic [MantBits-1:0] mant;
    logic [15:0]         dexp;
    logic [LineBits-1:0] line;
    logic                last;
  } res_t;

  function automatic logic [3:0] kw_len(input logic [3:0] k);
    unique case (k)
      4'd0: kw_len = 4'd3;
      4'd1: kw_len = 4'd8;
      4'd2: kw_len = 4'd2;
      4'd3: kw_len = 4'd4;
      4'd4: kw_len = 4'd5;
      4'd5: kw_len = 4'd3;
      4'd6: kw_len = 4'd8;
      4'd7: kw_len = 4'd5;
      default: kw_len = 4'd6;
    endcase
  endfunction

  // keyword text, 8 chars max, index by position
  function automatic logic [7:0] kw_char(input logic [3:0] k, input logic [3:0] p);
    logic [63:0] s;
    unique case (k)
      4'd0: s = "var";
      4'd1: s = "function";
      4'd2: s = "if";
      4'd3: s = "else";
      4'd4: s = "while";
      4'd5: s = "for";
      4'd6: s = "continue";
      4'd7: s = "break";
      default: s = "return";
    endcase
    kw_char = 8'h00;
    if (p < kw_len(k)) kw_char = s[8*(kw_len(k)-1-p) +: 8];
  endfunction

  function automatic logic [5:0] single_op(input logic [7:0] c);
    case (c)
      ",": single_op = 6'd14;
      ";": single_op = 6'd15;
      "(": single_op = 6'd16;
      ")": single_op = 6'd17;
      "{": single_op = 6'd18;
      "}": single_op = 6'd19;
      "*": single_op = 6'd22;
      "%": single_op = 6'd24;
      "+": single_op = 6'd25;
      "-": single_op = 6'd26;
      "<": single_op = 6'd29;
      ">": single_op = 6'd30;
      default: single_op = 6'd0;
    endcase
  endfunction

endpackage
`default_nettype wire

### rtl/core/script_token_lexer.sv
// ----------------------------------------------------------------------------
// script_token_lexer: streaming lexer for a small C-like script language
// Front end lexes one byte per cycle while the queue has room; results drain through a queue.
// ----------------------------------------------------------------------------
//  channel  | handshake          | payload
//  source   | push / full        | char_in_i, end_of_text_i
//  results  | pop / empty        | record_kind_o .. last_o
//
// One byte per cycle is taken while the queue has room for three records.
// A byte giving up to two results is lexed in the cycle it is taken; the
// result rate is one per cycle while pop is high, set by the single queue read port.
// Reset clears lexer state and the queue; no clearing pass.
// ----------------------------------------------------------------------------
`default_nettype none
module script_token_lexer (
  input  wire logic         clk_i,
  input  wire logic         rst_ni,
  input  wire logic         push,
  output logic              full,
  input  wire logic [7:0]   char_in_i,
  input  wire logic         end_of_text_i,
  output logic              empty,
  input  wire logic         pop,
  output logic              record_kind_o,
  output logic [5:0]        token_kind_o,
  output logic [7:0]        text_byte_o,
  output logic [31:0]       int_value_o,
  output logic [stl_pkg::MantBits-1:0] mantissa_o,
  output logic signed [15:0] dec_exponent_o,
  output logic [stl_pkg::LineBits-1:0] line_number_o,
  output logic              last_o
);

  stl_pkg::res_t res [3];
  stl_pkg::res_t head;
  logic [1:0] cnt;
  logic room;

  assign full = !room;

  stl_front u_front (
    .clk_i, .rst_ni, .take_i(push && room), .char_in_i, .end_of_text_i,
    .res_o(res), .cnt_o(cnt)
  );

  stl_queue u_queue (
    .clk_i, .rst_ni, .wr_i(res), .wr_cnt_i(cnt), .room_o(room),
    .rd_i(pop), .empty_o(empty), .rd_o(head)
  );

  assign record_kind_o  = head.rec;
  assign token_kind_o   = head.tok;
  assign text_byte_o    = head.byte_v;
  assign int_value_o    = head.ival;
  assign mantissa_o     = head.mant;
  assign dec_exponent_o = head.dexp;
  assign line_number_o  = head.line;
  assign last_o         = head.last;

endmodule
`default_nettype wire

### rtl/core/stl_front.sv
// ----------------------------------------------------------------------------
// stl_front: byte classifier and lexer state
// Consumes one byte per cycle while take_i is high, updates the token state and
// writes up to two result records into the queue in the cycle the byte is taken.
// ----------------------------------------------------------------------------
`default_nettype none
module stl_front (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                take_i,
  input  wire logic [7:0]          char_in_i,
  input  wire logic                end_of_text_i,
  output stl_pkg::res_t            res_o [3],
  output logic [1:0]               cnt_o
);

  localparam logic [stl_pkg::LineBits-1:0] LineMax = '1;
  localparam logic [stl_pkg::MantBits-1:0] MantMax = '1;

  stl_pkg::mode_e mode_q, mode_d;
  logic [7:0]  held_q, held_d;
  logic [31:0] int_q, int_d;
  logic [stl_pkg::MantBits-1:0] mant_q, mant_d;
  logic [15:0] frac_q, frac_d;
  logic [15:0] exp_q, exp_d;
  logic        neg_q, neg_d;
  logic [stl_pkg::LineBits-1:0] line_q, line_d;
  logic [8:0]  hits_q, hits_d;
  logic [3:0]  ilen_q, ilen_d;

  stl_pkg::res_t r [3];
  logic [1:0] n;

  // values computed once from the registered state and the input byte
  logic [3:0]  dig;
  logic        is_dig, is_id;
  logic [stl_pkg::MantBits+3:0] mant_x10;
  logic [stl_pkg::MantBits-1:0] mant_pushed;
  logic [19:0] exp_x10;
  logic [15:0] exp_pushed;
  logic signed [17:0] e_full;
  logic [15:0] e_sat;
  logic [5:0]  id_tok;
  logic [8:0]  hits_next;

  always_comb begin
    dig      = char_in_i[3:0];
    is_dig   = (char_in_i >= "0") && (char_in_i <= "9");
    is_id    = (char_in_i >= "A") && (char_in_i <= "z");
    mant_x10 = {4'd0, mant_q} * 4'd10 + {{stl_pkg::MantBits{1'b0}}, dig};
    mant_pushed = (mant_x10[stl_pkg::MantBits+3:stl_pkg::MantBits] != 4'd0) ? MantMax
                  : mant_x10[stl_pkg::MantBits-1:0];
    exp_x10  = {4'd0, exp_q} * 4'd10 + {16'd0, dig};
    exp_pushed = (exp_x10[19:16] != 4'd0) ? 16'hFFFF : exp_x10[15:0];
    e_full   = (neg_q ? -$signed({2'b00, exp_q}) : $signed({2'b00, exp_q}))
               - $signed({2'b00, frac_q});
    if (e_full < -18'sd32768)     e_sat = 16'h8000;
    else if (e_full > 18'sd32767) e_sat = 16'h7FFF;
    else                          e_sat = e_full[15:0];
    id_tok = stl_pkg::TkIdent;
    for (int k = 0; k < 9; k++) begin
      if (hits_q[k] && ilen_q == stl_pkg::kw_len(4'(k))) id_tok = stl_pkg::TkKw0 + 6'(k);
    end
  end

  // identifier keyword tracking for a byte appended at length len
  function automatic logic [8:0] hits_upd(input logic [8:0] h, input logic [3:0] len,
                                          input logic [7:0] c);
    logic [8:0] o;
    o = h;
    for (int k = 0; k < 9; k++) begin
      if (len >= stl_pkg::kw_len(4'(k)) || stl_pkg::kw_char(4'(k), len) != c) o[k] = 1'b0;
    end
    return o;
  endfunction

  always_comb begin
    hits_next = hits_upd(hits_q, ilen_q, char_in_i);
  end

  always_comb begin
    stl_pkg::res_t z;
    logic do_close, do_begin;
    logic [stl_pkg::LineBits-1:0] ln;
    logic [5:0] op;
    z = '0;
    for (int i = 0; i < 3; i++) r[i] = '0;
    n = 2'd0;
    mode_d = mode_q; held_d = held_q; int_d = int_q; mant_d = mant_q;
    frac_d = frac_q; exp_d = exp_q; neg_d = neg_q; line_d = line_q;
    hits_d = hits_q; ilen_d = ilen_q;
    do_close = 1'b0; do_begin = 1'b0;
    ln = line_q;
    op = stl_pkg::single_op(char_in_i);

    if (end_of_text_i) begin
      do_close = 1'b1;
    end else begin
      unique case (mode_q)
        stl_pkg::M_SLASH: begin
          if (char_in_i == "/") mode_d = stl_pkg::M_COMMENT;
          else begin do_close = 1'b1; do_begin = 1'b1; end
        end
        stl_pkg::M_COMMENT: begin
          if (char_in_i == 8'h0A) begin
            mode_d = stl_pkg::M_IDLE;
            if (line_q != LineMax) line_d = line_q + 1'b1;
          end
        end
        stl_pkg::M_INT: begin
          if (is_dig) begin
            int_d  = 32'(int_q * 32'd10) + {28'd0, dig};
            mant_d = mant_pushed;
          end else if (char_in_i == ".") mode_d = stl_pkg::M_FRAC;
          else if (char_in_i == "e") mode_d = stl_pkg::M_EXP_START;
          else begin do_close = 1'b1; do_begin = 1'b1; end
        end
        stl_pkg::M_FRAC: begin
          if (is_dig) begin
            mant_d = mant_pushed;
            if (frac_q != 16'hFFFF) frac_d = frac_q + 1'b1;
          end else if (char_in_i == "e") mode_d = stl_pkg::M_EXP_START;
          else begin do_close = 1'b1; do_begin = 1'b1; end
        end
        stl_pkg::M_EXP_START, stl_pkg::M_EXP_SIGN, stl_pkg::M_EXP_DIG: begin
          if (is_dig) begin
            exp_d = exp_pushed;
            mode_d = stl_pkg::M_EXP_DIG;
          end else if (char_in_i == "-" && mode_q == stl_pkg::M_EXP_START) begin
            neg_d = 1'b1;
            mode_d = stl_pkg::M_EXP_SIGN;
          end else begin do_close = 1'b1; do_begin = 1'b1; end
        end
        stl_pkg::M_STR: begin
          if (char_in_i == "\"") begin
            z.rec = 1'b1; z.tok = stl_pkg::TkStr; z.line = ln;
            r[0] = z; n = 2'd1;
            mode_d = stl_pkg::M_IDLE;
          end else if (char_in_i == "\\") mode_d = stl_pkg::M_STR_ESC;
          else begin
            z.tok = stl_pkg::TkStr; z.byte_v = char_in_i; z.line = ln;
            r[0] = z; n = 2'd1;
            if (char_in_i == 8'h0A && line_q != LineMax) line_d = line_q + 1'b1;
          end
        end
        stl_pkg::M_STR_ESC: begin
          z.tok = stl_pkg::TkStr; z.line = ln;
          if (char_in_i == "n")      z.byte_v = 8'h0A;
          else if (char_in_i == "t") z.byte_v = 8'h09;
          else if (char_in_i == "r") z.byte_v = 8'h0D;
          else                       z.byte_v = char_in_i;
          r[0] = z; n = 2'd1;
          if (char_in_i == 8'h0A && line_q != LineMax) line_d = line_q + 1'b1;
          mode_d = stl_pkg::M_STR;
        end
        stl_pkg::M_IDENT: begin
          if (is_id || is_dig) begin
            hits_d = hits_next;
            if (ilen_q != 4'hF) ilen_d = ilen_q + 1'b1;
            z.tok = stl_pkg::TkIdent; z.byte_v = char_in_i; z.line = ln;
            r[0] = z; n = 2'd1;
          end else begin do_close = 1'b1; do_begin = 1'b1; end
        end
        stl_pkg::M_OP_PEND: begin
          z.rec = 1'b1; z.line = ln;
          if (char_in_i == "=" && (held_q == "=" || held_q == "!")) begin
            z.tok = (held_q == "=") ? stl_pkg::TkEq : stl_pkg::TkNe;
            r[0] = z; n = 2'd1; mode_d = stl_pkg::M_IDLE;
          end else if ((held_q == "|" && char_in_i == "|") ||
                       (held_q == "&" && char_in_i == "&")) begin
            z.tok = (held_q == "|") ? stl_pkg::TkOr : stl_pkg::TkAnd;
            r[0] = z; n = 2'd1; mode_d = stl_pkg::M_IDLE;
          end else begin do_close = 1'b1; do_begin = 1'b1; end
        end
        default: do_begin = 1'b1;
      endcase
    end

    if (do_close) begin
      z = '0; z.rec = 1'b1; z.line = ln;
      case (mode_q)
        stl_pkg::M_SLASH: begin z.tok = stl_pkg::TkDiv; r[0] = z; n = 2'd1; end
        stl_pkg::M_INT: begin z.tok = stl_pkg::TkInt; z.ival = int_q; r[0] = z; n = 2'd1; end
        stl_pkg::M_FRAC, stl_pkg::M_EXP_START, stl_pkg::M_EXP_SIGN,
        stl_pkg::M_EXP_DIG: begin
          z.tok = stl_pkg::TkFloat; z.mant = mant_q; z.dexp = e_sat;
          r[0] = z; n = 2'd1;
        end
        stl_pkg::M_STR, stl_pkg::M_STR_ESC: begin
          z.tok = stl_pkg::TkOpenStr; r[0] = z; n = 2'd1;
        end
        stl_pkg::M_IDENT: begin z.tok = id_tok; r[0] = z; n = 2'd1; end
        stl_pkg::M_OP_PEND: begin
          if (held_q == "=")      z.tok = stl_pkg::TkAssign;
          else if (held_q == "!") z.tok = stl_pkg::TkNot;
          else begin z.tok = stl_pkg::TkBad; z.byte_v = held_q; end
          r[0] = z; n = 2'd1;
        end
        default: ;
      endcase
      mode_d = stl_pkg::M_IDLE;
    end

    if (end_of_text_i) begin
      z = '0; z.rec = 1'b1; z.tok = stl_pkg::TkEof; z.line = ln;
      r[n] = z; n = n + 1'b1;
      mode_d = stl_pkg::M_IDLE;
      line_d = '0;
    end else if (do_begin) begin
      z = '0; z.line = ln;
      mode_d = stl_pkg::M_IDLE;
      if (char_in_i == " " || char_in_i == 8'h09 || char_in_i == 8'h0D ||
          char_in_i == 8'h0A) begin
        if (char_in_i == 8'h0A && line_q != LineMax) line_d = line_q + 1'b1;
      end else if (is_dig) begin
        mode_d = stl_pkg::M_INT;
        int_d  = {28'd0, dig};
        mant_d = {{(stl_pkg::MantBits-4){1'b0}}, dig};
        frac_d = '0; exp_d = '0; neg_d = 1'b0;
      end else if (char_in_i == "\"") begin
        mode_d = stl_pkg::M_STR;
      end else if (is_id) begin
        mode_d = stl_pkg::M_IDENT;
        hits_d = hits_upd(9'h1FF, 4'd0, char_in_i);
        ilen_d = 4'd1;
        z.tok = stl_pkg::TkIdent; z.byte_v = char_in_i;
        r[n] = z; n = n + 1'b1;
      end else if (char_in_i == "/") begin
        mode_d = stl_pkg::M_SLASH;
      end else if (char_in_i == "=" || char_in_i == "!" || char_in_i == "|" ||
                   char_in_i == "&") begin
        mode_d = stl_pkg::M_OP_PEND;
        held_d = char_in_i;
      end else if (op != 6'd0) begin
        z.rec = 1'b1; z.tok = op; r[n] = z; n = n + 1'b1;
      end else begin
        z.rec = 1'b1; z.tok = stl_pkg::TkBad; z.byte_v = char_in_i;
        r[n] = z; n = n + 1'b1;
      end
    end
    if (n != 2'd0) r[n-1'b1].last = 1'b1;
  end

  always_comb begin
    res_o = r;
    cnt_o = take_i ? n : 2'd0;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q <= stl_pkg::M_IDLE;
      held_q <= '0; int_q <= '0; mant_q <= '0; frac_q <= '0; exp_q <= '0;
      neg_q <= 1'b0; line_q <= '0; hits_q <= 9'h1FF; ilen_q <= '0;
    end else if (take_i) begin
      mode_q <= mode_d; held_q <= held_d; int_q <= int_d; mant_q <= mant_d;
      frac_q <= frac_d; exp_q <= exp_d; neg_q <= neg_d; line_q <= line_d;
      hits_q <= hits_d; ilen_q <= ilen_d;
    end
  end

endmodule
`default_nettype wire

### rtl/core/stl_queue.sv
// ----------------------------------------------------------------------------
// stl_queue: result queue between lexer and output port
// Takes up to three records per cycle, gives one per cycle while read and not empty.
// ----------------------------------------------------------------------------
`default_nettype none
module stl_queue (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  var stl_pkg::res_t  wr_i [3],
  input  wire logic [1:0]    wr_cnt_i,
  output logic               room_o,
  input  wire logic          rd_i,
  output logic               empty_o,
  output stl_pkg::res_t      rd_o
);

  stl_pkg::res_t mem_q [stl_pkg::QDepth];
  logic [stl_pkg::QAw-1:0] wp_q, rp_q;
  logic [stl_pkg::QAw:0]   cnt_q;

  // accept only with room for a full burst of three
  assign room_o  = (cnt_q <= 3'(stl_pkg::QDepth - 3)) ||
                   ((cnt_q == 3'(stl_pkg::QDepth - 2)) && rd_i && !empty_o);
  assign empty_o = (cnt_q == '0);
  assign rd_o    = mem_q[rp_q];

  always_ff @(posedge clk_i) begin
    for (int i = 0; i < 3; i++) begin
      if (2'(i) < wr_cnt_i) mem_q[wp_q + stl_pkg::QAw'(i)] <= wr_i[i];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q <= '0; rp_q <= '0; cnt_q <= '0;
    end else begin
      wp_q  <= wp_q + stl_pkg::QAw'(wr_cnt_i);
      rp_q  <= rp_q + stl_pkg::QAw'(rd_i && !empty_o);
      cnt_q <= cnt_q + {1'b0, wr_cnt_i} - {2'b0, (rd_i && !empty_o)};
    end
  end

endmodule
`default_nettype wire

### rtl/core/stl_checker.sv
// ----------------------------------------------------------------------------
// stl_checker: port-level checks for the script token lexer
// Watches the queue handshakes and record encoding.
// ----------------------------------------------------------------------------
`default_nettype none
module stl_checker (
  input wire logic        clk_i,
  input wire logic        rst_ni,
  input wire logic        push,
  input wire logic        full,
  input wire logic        empty,
  input wire logic        pop,
  input wire logic        record_kind_o,
  input wire logic [5:0]  token_kind_o,
  input wire logic [31:0] int_value_o,
  input wire logic        end_of_text_i
);

  // text bytes belong to strings or identifiers only
  a_text_kind: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty && !record_kind_o) |->
      (token_kind_o == stl_pkg::TkStr || token_kind_o == stl_pkg::TkIdent))
    else $error("text byte with bad token kind");

  a_kind_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !empty |-> token_kind_o <= stl_pkg::TkOpenStr)
    else $error("token kind out of range");

  a_int_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty && token_kind_o != stl_pkg::TkInt) |-> int_value_o == 32'd0)
    else $error("int value on non-int record");

  // end of text always yields at least one result
  a_eot_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (push && !full && end_of_text_i) |=> !empty)
    else $error("end of text gave no result");

endmodule

bind script_token_lexer stl_checker u_stl_checker (
  .clk_i, .rst_ni, .push, .full, .empty, .pop, .record_kind_o, .token_kind_o,
  .int_value_o, .end_of_text_i
);
`default_nettype wire

### tb/tb_script_token_lexer.sv
// ----------------------------------------------------------------------------
// tb_script_token_lexer: self-checking bench for the script token lexer
// Feeds directed and random source text, predicts every token and text-byte
// record in a scoreboard, and compares each popped record field by field.
// ----------------------------------------------------------------------------
module tb_script_token_lexer;
  timeunit 1ns;
  timeprecision 1ps;

  // Tracks lexer state and holds the records still owed by the block.
  class lex_scoreboard;
    stl_pkg::mode_e  mode;
    logic [7:0]      held;
    logic [31:0]     int_acc;
    logic [63:0]     mant_acc;
    int unsigned     frac_cnt, exp_val, line_cnt, id_len;
    bit              exp_neg;
    logic [8:0]      kw_live;
    string           kw_words[9] = '{"var", "function", "if", "else", "while", "for",
                                     "continue", "break", "return"};
    stl_pkg::res_t   owed[$];
    stl_pkg::res_t   step_recs[$];
    int              errors;

    function new();
      mode = stl_pkg::M_IDLE; held = 0; int_acc = 0; mant_acc = 0; frac_cnt = 0;
      exp_val = 0; exp_neg = 0; line_cnt = 0; kw_live = '1; id_len = 0; errors = 0;
    endfunction

    function void put(bit rec, logic [5:0] tok, logic [7:0] b = 0, logic [31:0] iv = 0,
                      logic [63:0] m = 0, logic [15:0] de = 0);
      stl_pkg::res_t r;
      r.rec = rec; r.tok = tok; r.byte_v = b; r.ival = iv; r.mant = m; r.dexp = de;
      r.line = (line_cnt > 65535) ? 16'hFFFF : line_cnt[15:0];
      r.last = 0;
      step_recs.push_back(r);
    endfunction

    function void bump_line();
      if (line_cnt < 65535) line_cnt++;
    endfunction

    function void mant_digit(int unsigned d);
      if (mant_acc > (64'hFFFF_FFFF_FFFF_FFFF - d) / 10) mant_acc = '1;
      else mant_acc = mant_acc * 10 + d;
    endfunction

    function void ident_byte(logic [7:0] c);
      for (int k = 0; k < 9; k++)
        if (kw_live[k] && (id_len >= kw_words[k].len() || kw_words[k][id_len] != c))
          kw_live[k] = 0;
      if (id_len < 15) id_len++;
      put(0, stl_pkg::TkIdent, c);
    endfunction

    function void close_token();
      int e;
      logic [5:0] tok;
      case (mode)
        stl_pkg::M_SLASH: put(1, stl_pkg::TkDiv);
        stl_pkg::M_INT:   put(1, stl_pkg::TkInt, 0, int_acc);
        stl_pkg::M_FRAC, stl_pkg::M_EXP_START, stl_pkg::M_EXP_SIGN,
        stl_pkg::M_EXP_DIG: begin
          e = exp_neg ? -int'(exp_val) : int'(exp_val);
          e -= int'(frac_cnt);
          if (e < -32768) e = -32768;
          if (e > 32767) e = 32767;
          put(1, stl_pkg::TkFloat, 0, 0, mant_acc, e[15:0]);
        end
        stl_pkg::M_STR, stl_pkg::M_STR_ESC: put(1, stl_pkg::TkOpenStr);
        stl_pkg::M_IDENT: begin
          tok = stl_pkg::TkIdent;
          for (int k = 0; k < 9; k++)
            if (kw_live[k] && id_len == kw_words[k].len()) tok = stl_pkg::TkKw0 + k;
          put(1, tok);
        end
        stl_pkg::M_OP_PEND: begin
          if (held == "=") put(1, stl_pkg::TkAssign);
          else if (held == "!") put(1, stl_pkg::TkNot);
          else put(1, stl_pkg::TkBad, held);
        end
        default: ;
      endcase
      mode = stl_pkg::M_IDLE;
    endfunction

    function void start_token(logic [7:0] c);
      mode = stl_pkg::M_IDLE;
      if (c == " " || c == "\t" || c == 8'h0D || c == "\n") begin
        if (c == "\n") bump_line();
      end else if (c >= "0" && c <= "9") begin
        mode = stl_pkg::M_INT; int_acc = c - "0"; mant_acc = 0; mant_digit(c - "0");
        frac_cnt = 0; exp_val = 0; exp_neg = 0;
      end else if (c == "\"") begin
        mode = stl_pkg::M_STR;
      end else if (c >= "A" && c <= "z") begin
        mode = stl_pkg::M_IDENT; kw_live = '1; id_len = 0; ident_byte(c);
      end else if (c == "/") begin
        mode = stl_pkg::M_SLASH;
      end else if (c == "=" || c == "!" || c == "|" || c == "&") begin
        mode = stl_pkg::M_OP_PEND; held = c;
      end else if (stl_pkg::single_op(c) != 0) begin
        put(1, stl_pkg::single_op(c));
      end else begin
        put(1, stl_pkg::TkBad, c);
      end
    endfunction

    // Lex one accepted byte and queue the records it yields.
    function void note_input(logic [7:0] c, bit eot);
      bit dig;
      dig = (c >= "0" && c <= "9");
      step_recs.delete();
      if (eot) begin
        close_token();
        put(1, stl_pkg::TkEof);
        mode = stl_pkg::M_IDLE; line_cnt = 0;
      end else begin
        case (mode)
          stl_pkg::M_SLASH: begin
            if (c == "/") mode = stl_pkg::M_COMMENT;
            else begin close_token(); start_token(c); end
          end
          stl_pkg::M_COMMENT: begin
            if (c == "\n") begin bump_line(); mode = stl_pkg::M_IDLE; end
          end
          stl_pkg::M_INT: begin
            if (dig) begin int_acc = int_acc * 10 + (c - "0"); mant_digit(c - "0"); end
            else if (c == ".") mode = stl_pkg::M_FRAC;
            else if (c == "e") mode = stl_pkg::M_EXP_START;
            else begin close_token(); start_token(c); end
          end
          stl_pkg::M_FRAC: begin
            if (dig) begin mant_digit(c - "0"); if (frac_cnt < 65535) frac_cnt++; end
            else if (c == "e") mode = stl_pkg::M_EXP_START;
            else begin close_token(); start_token(c); end
          end
          stl_pkg::M_EXP_START, stl_pkg::M_EXP_SIGN, stl_pkg::M_EXP_DIG: begin
            if (dig) begin
              exp_val = exp_val * 10 + (c - "0");
              if (exp_val > 65535) exp_val = 65535;
              mode = stl_pkg::M_EXP_DIG;
            end else if (c == "-" && mode == stl_pkg::M_EXP_START) begin
              exp_neg = 1; mode = stl_pkg::M_EXP_SIGN;
            end else begin close_token(); start_token(c); end
          end
          stl_pkg::M_STR: begin
            if (c == "\"") begin put(1, stl_pkg::TkStr); mode = stl_pkg::M_IDLE; end
            else if (c == "\\") mode = stl_pkg::M_STR_ESC;
            else begin put(0, stl_pkg::TkStr, c); if (c == "\n") bump_line(); end
          end
          stl_pkg::M_STR_ESC: begin
            if (c == "n") put(0, stl_pkg::TkStr, "\n");
            else if (c == "t") put(0, stl_pkg::TkStr, "\t");
            else if (c == "r") put(0, stl_pkg::TkStr, 8'h0D);
            else put(0, stl_pkg::TkStr, c);
            if (c == "\n") bump_line();
            mode = stl_pkg::M_STR;
          end
          stl_pkg::M_IDENT: begin
            if ((c >= "A" && c <= "z") || dig) ident_byte(c);
            else begin close_token(); start_token(c); end
          end
          stl_pkg::M_OP_PEND: begin
            if (held == "=" && c == "=") begin
              put(1, stl_pkg::TkEq); mode = stl_pkg::M_IDLE;
            end else if (held == "!" && c == "=") begin
              put(1, stl_pkg::TkNe); mode = stl_pkg::M_IDLE;
            end else if (held == "|" && c == "|") begin
              put(1, stl_pkg::TkOr); mode = stl_pkg::M_IDLE;
            end else if (held == "&" && c == "&") begin
              put(1, stl_pkg::TkAnd); mode = stl_pkg::M_IDLE;
            end else begin close_token(); start_token(c); end
          end
          default: start_token(c);
        endcase
      end
      if (step_recs.size() > 0) step_recs[step_recs.size()-1].last = 1;
      foreach (step_recs[i]) owed.push_back(step_recs[i]);
    endfunction

    function void cmp(string fld, logic [63:0] exp_v, logic [63:0] got_v);
      if (exp_v !== got_v) begin
        errors++;
        $display("%0t: %s mismatch, expected %0h, actual %0h", $realtime, fld, exp_v, got_v);
      end
    endfunction

    function void check(stl_pkg::res_t got);
      stl_pkg::res_t e;
      if (owed.size() == 0) begin
        errors++;
        $display("%0t: unexpected record, expected none, actual %p", $realtime, got);
        return;
      end
      e = owed[0];
      owed.delete(0);
      cmp("record_kind", e.rec, got.rec);
      cmp("token_kind", e.tok, got.tok);
      cmp("text_byte", e.byte_v, got.byte_v);
      cmp("int_value", e.ival, got.ival);
      cmp("mantissa", e.mant, got.mant);
      cmp("dec_exponent", e.dexp, got.dexp);
      cmp("line_number", e.line, got.line);
      cmp("last", e.last, got.last);
    endfunction
  endclass

  localparam int IdleLimit = 3000;

  logic        clk_i = 0;
  logic        rst_ni = 0;
  logic        push = 0, pop = 0;
  logic        full, empty;
  logic [7:0]  char_in_i = 0;
  logic        end_of_text_i = 0;
  logic        record_kind_o, last_o;
  logic [5:0]  token_kind_o;
  logic [7:0]  text_byte_o;
  logic [31:0] int_value_o;
  logic [63:0] mantissa_o;
  logic signed [15:0] dec_exponent_o;
  logic [15:0] line_number_o;

  lex_scoreboard sb = new();
  int  bytes_sent = 0;
  int  idle_cycles = 0;
  int  rx_hold = 0;
  bit  tx_steady = 0, rx_steady = 0;

  script_token_lexer u_top (.*);

  always #2 clk_i = ~clk_i;

  always @(posedge clk_i) begin
    if ((push && !full) || (pop && !empty)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles > IdleLimit) begin
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  function automatic int pick_gap(bit steady);
    int r;
    r = $urandom_range(0, 99);
    if (steady || r < 55) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  task automatic send_byte(logic [7:0] c, bit eot = 0);
    int gap;
    gap = pick_gap(tx_steady);
    if (gap > 0) begin
      push <= 0;
      repeat (gap) @(posedge clk_i);
    end
    push <= 1; char_in_i <= c; end_of_text_i <= eot;
    @(posedge clk_i);
    while (full) @(posedge clk_i);
    sb.note_input(c, eot);
    bytes_sent++;
  endtask

  task automatic send_text(string s);
    for (int i = 0; i < s.len(); i++) send_byte(s[i]);
  endtask

  function automatic string digits(int n);
    string s = "";
    for (int i = 0; i < n; i++) s = {s, string'(8'($urandom_range("0", "9")))};
    return s;
  endfunction

  // Random well-formed fragment, with the occasional broken one.
  function automatic string fragment();
    string s = "";
    string ops[] = '{"==", "!=", "||", "&&", "=", "!", "|", "&", "/", ",", ";", "(", ")",
                     "{", "}", "*", "%", "+", "-", "<", ">"};
    string esc[] = '{"\\n", "\\t", "\\r", "\\\\", "\\\"", "\\q", "\n", " "};
    case ($urandom_range(0, 8))
      0: s = sb.kw_words[$urandom_range(0, 8)];
      1: begin
        s = string'(8'($urandom_range("A", "z")));
        repeat ($urandom_range(0, 6))
          s = {s, string'(8'($urandom_range(0, 1) ? $urandom_range("A", "z")
                                                  : $urandom_range("0", "9")))};
      end
      2: s = digits($urandom_range(1, 12));
      3: begin
        s = digits($urandom_range(1, $urandom_range(0, 5) == 0 ? 24 : 4));
        if ($urandom_range(0, 2)) s = {s, ".", digits($urandom_range(0, 4))};
        if ($urandom_range(0, 1)) begin
          s = {s, "e"};
          if ($urandom_range(0, 1)) s = {s, "-"};
          s = {s, digits($urandom_range(0, $urandom_range(0, 5) == 0 ? 7 : 2))};
        end
      end
      4: begin
        s = "\"";
        repeat ($urandom_range(0, 5))
          s = {s, $urandom_range(0, 2) == 0 ? esc[$urandom_range(0, esc.size()-1)]
                                            : string'(8'($urandom_range("#", "~")))};
        if ($urandom_range(0, 9)) s = {s, "\""};
      end
      5: s = ops[$urandom_range(0, ops.size()-1)];
      6: s = {"// c", digits(2), "\n"};
      7: s = $urandom_range(0, 1) ? "\n" : "\t \r";
      default: s = "";
    endcase
    return s;
  endfunction

  task automatic wait_drained();
    push <= 0;
    while (sb.owed.size() != 0) @(posedge clk_i);
    repeat (6) @(posedge clk_i);
  endtask

  // Result side: random stalls, plus a long hold-off on request.
  initial begin
    @(posedge rst_ni);
    forever begin
      int gap;
      gap = rx_hold > 0 ? rx_hold : pick_gap(rx_steady);
      rx_hold = 0;
      if (gap > 0) begin
        pop <= 0;
        repeat (gap) @(posedge clk_i);
      end
      pop <= 1;
      @(posedge clk_i);
      while (empty) @(posedge clk_i);
      sb.check('{record_kind_o, token_kind_o, text_byte_o, int_value_o, mantissa_o,
                 dec_exponent_o, line_number_o, last_o});
    end
  end

  initial begin
    string frag;
    repeat (12) @(posedge clk_i);
    rst_ni <= 1;
    @(posedge clk_i);

    // directed: keywords, operators, numbers, strings, comments, bad bytes
    send_text("while x9 returnx==!=||&&=!|&/2.5e-3 1e \"a\\tb\"\n//c\n#");
    send_byte(8'hFF);
    send_text("99999999999999999999999 \"op");
    send_byte(0, 1);
    send_text("//z");
    send_byte(8'h00, 1);

    // receiver holds off while text keeps coming, so the queue fills up
    rx_hold = 200;
    tx_steady = 1;
    send_text("var fn=\"hello\\n\" if else for continue break function;");
    tx_steady = 0;
    wait_drained();

    while (bytes_sent < 380) begin
      tx_steady = ($urandom_range(0, 7) == 0);
      rx_steady = ($urandom_range(0, 7) == 0);
      case ($urandom_range(0, 19))
        0: send_byte($urandom_range(0, 255));
        1: send_byte($urandom_range(0, 255), 1);
        2: wait_drained();
        default: begin
          frag = fragment();
          send_text(frag);
          if ($urandom_range(0, 3)) send_byte(" ");
        end
      endcase
    end
    send_byte(0, 1);

    wait_drained();
    repeat (20) @(posedge clk_i);
    if (sb.errors == 0) $display("Testbench completed without errors");
    else $display("Testbench completed WITH ERRORS");
    $finish;
  end
endmodule

### files.f
rtl/core/stl_pkg.sv
rtl/core/stl_front.sv
rtl/core/stl_queue.sv
rtl/core/script_token_lexer.sv
rtl/core/stl_checker.sv
tb/tb_script_token_lexer.sv
